// File: sv/pfa_pkg.sv
// Shared types, codes and helpers for the page frame allocator.
// No dependencies; used by pfa_table, pfa_ctrl and page_frame_allocator.
`timescale 1ns / 1ps
`default_nettype none
package pfa_pkg;

    localparam int MAX_FRAMES = 256;
    localparam int MAX_RUN    = 32;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);

    localparam logic [1:0] KIND_FREE   = 2'd0;
    localparam logic [1:0] KIND_USER   = 2'd1;
    localparam logic [1:0] KIND_KERNEL = 2'd2;

    localparam logic [1:0] CMD_USER   = 2'd0;
    localparam logic [1:0] CMD_KERNEL = 2'd1;
    localparam logic [1:0] CMD_FREE   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_NO_VICTIM = 2'd2;
    localparam logic [1:0] ST_BAD_FRAME = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pid;
        logic [19:0] tag;
    } entry_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] frame;
        logic               evicted;
        logic [15:0]        pid;
        logic [19:0]        page;
        logic [19:0]        tag;
        logic               last;
    } result_t;

    function automatic logic [FRAME_W-1:0] wrap_next(input logic [FRAME_W-1:0] idx,
                                                     input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] inc;
        begin
            inc = {1'b0, idx} + COUNT_W'(1);
            wrap_next = (inc == n) ? '0 : inc[FRAME_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// File: sv/pfa_table.sv
// Frame table: one synchronous memory of entries, one write and one read port.
// Per-entry valid bits make unwritten entries read as free. Uses pfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfa_table (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [pfa_pkg::FRAME_W-1:0] wr_addr,
    input  wire pfa_pkg::entry_t             wr_data,
    input  wire logic                        rd_en,
    input  wire logic [pfa_pkg::FRAME_W-1:0] rd_addr,
    output pfa_pkg::entry_t                  rd_data
);
    pfa_pkg::entry_t                    mem [pfa_pkg::MAX_FRAMES];
    logic [pfa_pkg::MAX_FRAMES-1:0]     valid_reg;
    pfa_pkg::entry_t                    q_reg;
    logic                               q_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                q_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = q_valid_reg ? q_reg : '0;

endmodule
`default_nettype wire

// File: sv/pfa_ctrl.sv
// Command sequencer: scans the frame table through its read port, writes back
// updates and hands results out one at a time. Uses pfa_pkg and pfa_table.
`timescale 1ns / 1ps
`default_nettype none
module pfa_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [pfa_pkg::COUNT_W-1:0] n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  command,
    input  wire logic [15:0]                 owner_pid,
    input  wire logic [19:0]                 virtual_page,
    input  wire logic [5:0]                  run_length,
    input  wire logic [7:0]                  free_frame,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output pfa_pkg::result_t                 res
);
    localparam int FW = pfa_pkg::FRAME_W;
    localparam int CW = pfa_pkg::COUNT_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_SCAN  = 6'b000100,
        S_FCHK  = 6'b001000,
        S_FILL  = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        M_FREEMID = 3'd0,
        M_VICTIM  = 3'd1,
        M_COUNT   = 3'd2,
        M_FIT     = 3'd3,
        M_KFREE   = 3'd4
    } mode_t;

    state_t            state_reg, state_next, ret_reg, ret_next;
    mode_t             mode_reg, mode_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [15:0]       pid_reg, pid_next;
    logic [19:0]       page_reg, page_next;
    logic [5:0]        want_reg, want_next;
    logic [7:0]        ff_reg, ff_next;
    logic [FW-1:0]     rd_idx_reg, rd_idx_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              pv_reg, pv_next;
    logic [FW-1:0]     pidx_reg, pidx_next;
    logic [CW-1:0]     free_cnt_reg, free_cnt_next;
    logic [5:0]        need_reg, need_next;
    logic [5:0]        run_reg, run_next;
    logic [FW-1:0]     start_reg, start_next;
    logic [19:0]       ftag_reg, ftag_next;
    logic [FW-1:0]     fill_idx_reg, fill_idx_next;
    logic [5:0]        fill_cnt_reg, fill_cnt_next;
    logic [FW-1:0]     vp_reg, vp_next;
    logic [19:0]       tag_ctr_reg, tag_ctr_next;
    pfa_pkg::result_t  res_reg, res_next;

    logic              wr_en, rd_en;
    logic [FW-1:0]     wr_addr, rd_addr;
    pfa_pkg::entry_t   wr_data, rd_data;
    logic              hit, issue;
    logic [FW-1:0]     vstart;

    pfa_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;

    always_comb
    begin
        hit = 1'b0;
        if (state_reg == S_SCAN && pv_reg)
        begin
            unique case (mode_reg)
                M_FREEMID: hit = (rd_data.kind == pfa_pkg::KIND_FREE);
                M_VICTIM:  hit = (rd_data.kind == pfa_pkg::KIND_USER);
                M_FIT:     hit = (rd_data.kind == pfa_pkg::KIND_FREE) &&
                                 (run_reg + 6'd1 == want_reg);
                default:   hit = 1'b0;
            endcase
        end
        issue = (state_reg == S_SCAN) && (cnt_reg < n) && !hit;
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        mode_next     = mode_reg;
        cmd_next      = cmd_reg;
        pid_next      = pid_reg;
        page_next     = page_reg;
        want_next     = want_reg;
        ff_next       = ff_reg;
        rd_idx_next   = rd_idx_reg;
        cnt_next      = cnt_reg;
        pv_next       = 1'b0;
        pidx_next     = pidx_reg;
        free_cnt_next = free_cnt_reg;
        need_next     = need_reg;
        run_next      = run_reg;
        start_next    = start_reg;
        ftag_next     = ftag_reg;
        fill_idx_next = fill_idx_reg;
        fill_cnt_next = fill_cnt_reg;
        vp_next       = vp_reg;
        tag_ctr_next  = tag_ctr_reg;
        res_next      = res_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;
        rd_en         = 1'b0;
        rd_addr       = rd_idx_reg;
        vstart        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    pid_next   = owner_pid;
                    page_next  = virtual_page;
                    want_next  = run_length;
                    ff_next    = free_frame;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                res_next      = '0;
                res_next.last = 1'b1;
                cnt_next      = '0;
                unique case (cmd_reg)
                    pfa_pkg::CMD_USER:
                    begin
                        mode_next   = M_FREEMID;
                        rd_idx_next = FW'(n >> 1);
                        state_next  = S_SCAN;
                    end
                    pfa_pkg::CMD_KERNEL:
                    begin
                        if (want_reg == 6'd0 || want_reg > 6'(pfa_pkg::MAX_RUN) ||
                            {{(CW-6){1'b0}}, want_reg} > n)
                        begin
                            res_next.status = pfa_pkg::ST_NO_SPACE;
                            ret_next        = S_IDLE;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            mode_next     = M_COUNT;
                            rd_idx_next   = '0;
                            free_cnt_next = '0;
                            state_next    = S_SCAN;
                        end
                    end
                    pfa_pkg::CMD_FREE:
                    begin
                        if ({1'b0, ff_reg} >= n)
                        begin
                            res_next.status = pfa_pkg::ST_BAD_FRAME;
                            ret_next        = S_IDLE;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = ff_reg;
                            state_next = S_FCHK;
                        end
                    end
                    default:
                    begin
                        res_next.status = pfa_pkg::ST_BAD_FRAME;
                        ret_next        = S_IDLE;
                        state_next      = S_EMIT;
                    end
                endcase
            end

            S_FCHK:
            begin
                res_next.frame = ff_reg;
                priority if (rd_data.kind == pfa_pkg::KIND_FREE)
                begin
                    res_next.status = pfa_pkg::ST_BAD_FRAME;
                    res_next.frame  = '0;
                    ret_next        = S_IDLE;
                    state_next      = S_EMIT;
                end
                else if (rd_data.kind == pfa_pkg::KIND_KERNEL)
                begin
                    ftag_next   = rd_data.tag;
                    mode_next   = M_KFREE;
                    rd_idx_next = '0;
                    cnt_next    = '0;
                    state_next  = S_SCAN;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = ff_reg;
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
            end

            S_SCAN:
            begin
                if (issue)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = rd_idx_reg;
                    rd_idx_next = pfa_pkg::wrap_next(rd_idx_reg, n);
                    cnt_next    = cnt_reg + CW'(1);
                    pv_next     = 1'b1;
                    pidx_next   = rd_idx_reg;
                end

                if (pv_reg)
                begin
                    unique case (mode_reg)
                        M_COUNT:
                        begin
                            if (rd_data.kind == pfa_pkg::KIND_FREE)
                            begin
                                free_cnt_next = free_cnt_reg + CW'(1);
                            end
                        end
                        M_FIT:
                        begin
                            if (rd_data.kind == pfa_pkg::KIND_FREE)
                            begin
                                if (run_reg == 6'd0)
                                begin
                                    start_next = pidx_reg;
                                end
                                run_next = run_reg + 6'd1;
                                if (hit)
                                begin
                                    fill_idx_next = (run_reg == 6'd0) ? pidx_reg : start_reg;
                                    fill_cnt_next = '0;
                                    state_next    = S_FILL;
                                end
                            end
                            else
                            begin
                                run_next = '0;
                            end
                        end
                        M_KFREE:
                        begin
                            if (rd_data.kind == pfa_pkg::KIND_KERNEL &&
                                rd_data.tag == ftag_reg)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = pidx_reg;
                            end
                        end
                        M_FREEMID:
                        begin
                            if (hit)
                            begin
                                wr_en          = 1'b1;
                                wr_addr        = pidx_reg;
                                wr_data.kind   = pfa_pkg::KIND_USER;
                                wr_data.pid    = pid_reg;
                                wr_data.tag    = page_reg;
                                res_next.frame = pidx_reg;
                                ret_next       = S_IDLE;
                                state_next     = S_EMIT;
                            end
                        end
                        default:
                        begin
                            // victim search
                            if (hit)
                            begin
                                wr_en            = 1'b1;
                                wr_addr          = pidx_reg;
                                if (cmd_reg == pfa_pkg::CMD_USER)
                                begin
                                    wr_data.kind = pfa_pkg::KIND_USER;
                                    wr_data.pid  = pid_reg;
                                    wr_data.tag  = page_reg;
                                end
                                vp_next          = pfa_pkg::wrap_next(pidx_reg, n);
                                res_next         = '0;
                                res_next.frame   = pidx_reg;
                                res_next.evicted = 1'b1;
                                res_next.pid     = rd_data.pid;
                                res_next.page    = rd_data.tag;
                                state_next       = S_EMIT;
                                cnt_next         = '0;
                                if (cmd_reg == pfa_pkg::CMD_USER)
                                begin
                                    res_next.last = 1'b1;
                                    ret_next      = S_IDLE;
                                end
                                else
                                begin
                                    res_next.last = 1'b0;
                                    ret_next      = S_SCAN;
                                    need_next     = need_reg - 6'd1;
                                    if (need_reg == 6'd1)
                                    begin
                                        mode_next   = M_FIT;
                                        rd_idx_next = '0;
                                        run_next    = '0;
                                    end
                                    else
                                    begin
                                        vstart      = ({1'b0, vp_next} >= n) ? '0 : vp_next;
                                        rd_idx_next = vstart;
                                    end
                                end
                            end
                        end
                    endcase
                end

                // whole pass evaluated without a hit
                if (cnt_reg == n && !pv_reg)
                begin
                    cnt_next = '0;
                    unique case (mode_reg)
                        M_FREEMID:
                        begin
                            mode_next   = M_VICTIM;
                            vstart      = ({1'b0, vp_reg} >= n) ? '0 : vp_reg;
                            rd_idx_next = vstart;
                        end
                        M_COUNT:
                        begin
                            if ({{(CW-6){1'b0}}, want_reg} > free_cnt_reg)
                            begin
                                need_next   = want_reg - free_cnt_reg[5:0];
                                mode_next   = M_VICTIM;
                                vstart      = ({1'b0, vp_reg} >= n) ? '0 : vp_reg;
                                rd_idx_next = vstart;
                            end
                            else
                            begin
                                mode_next   = M_FIT;
                                rd_idx_next = '0;
                                run_next    = '0;
                            end
                        end
                        M_FIT:
                        begin
                            res_next        = '0;
                            res_next.status = pfa_pkg::ST_NO_SPACE;
                            res_next.last   = 1'b1;
                            ret_next        = S_IDLE;
                            state_next      = S_EMIT;
                        end
                        M_KFREE:
                        begin
                            res_next.frame = ff_reg;
                            ret_next       = S_IDLE;
                            state_next     = S_EMIT;
                        end
                        default:
                        begin
                            res_next        = '0;
                            res_next.status = pfa_pkg::ST_NO_VICTIM;
                            res_next.last   = 1'b1;
                            ret_next        = S_IDLE;
                            state_next      = S_EMIT;
                        end
                    endcase
                end
            end

            S_FILL:
            begin
                wr_en         = 1'b1;
                wr_addr       = fill_idx_reg;
                wr_data.kind  = pfa_pkg::KIND_KERNEL;
                wr_data.tag   = tag_ctr_reg;
                fill_idx_next = fill_idx_reg + FW'(1);
                fill_cnt_next = fill_cnt_reg + 6'd1;
                if (fill_cnt_reg + 6'd1 == want_reg)
                begin
                    res_next       = '0;
                    res_next.frame = start_reg;
                    res_next.tag   = tag_ctr_reg;
                    res_next.last  = 1'b1;
                    tag_ctr_next   = tag_ctr_reg + 20'd1;
                    ret_next       = S_IDLE;
                    state_next     = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = ret_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            pv_reg      <= 1'b0;
            vp_reg      <= '0;
            tag_ctr_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            pv_reg      <= pv_next;
            vp_reg      <= vp_next;
            tag_ctr_reg <= tag_ctr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        cmd_reg      <= cmd_next;
        pid_reg      <= pid_next;
        page_reg     <= page_next;
        want_reg     <= want_next;
        ff_reg       <= ff_next;
        rd_idx_reg   <= rd_idx_next;
        cnt_reg      <= cnt_next;
        pidx_reg     <= pidx_next;
        free_cnt_reg <= free_cnt_next;
        need_reg     <= need_next;
        run_reg      <= run_next;
        start_reg    <= start_next;
        ftag_reg     <= ftag_next;
        fill_idx_reg <= fill_idx_next;
        fill_cnt_reg <= fill_cnt_next;
        res_reg      <= res_next;
    end

endmodule
`default_nettype wire

// File: sv/page_frame_allocator.sv
// Page frame allocator top level: frame count register, result output register.
// Depends on pfa_pkg and pfa_ctrl (which holds pfa_table).
//
// One command is worked on at a time; in_ready is high only between commands.
// The frame table sits in a single memory with one read and one write port,
// and the scanning commands walk it through the read port at one entry per
// cycle, except while an eviction result waits to be taken, so time scales
// with the managed frame count n: a user allocation scans for a free frame
// and, failing that, for a victim; a kernel allocation makes one counting
// pass, one pass per eviction and one placement pass, then writes its run
// frame by frame; freeing a user frame checks and clears it, a kernel run
// takes one pass. No clearing pass follows reset. Each result waits in an
// output register; work goes on while it is untaken, up to the next result.
`timescale 1ns / 1ps
`default_nettype none
module page_frame_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        frame_count_we,
    input  wire logic [8:0]  frame_count_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] owner_pid,
    input  wire logic [19:0] virtual_page,
    input  wire logic [5:0]  run_length,
    input  wire logic [7:0]  free_frame,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [7:0]       frame,
    output logic             evicted,
    output logic [15:0]      evicted_pid,
    output logic [19:0]      evicted_page,
    output logic [19:0]      kernel_tag,
    output logic             last
);
    localparam int CW = pfa_pkg::COUNT_W;

    logic [8:0]        frame_count_reg;
    logic [CW-1:0]     n;
    logic              res_valid, res_ready;
    pfa_pkg::result_t  res;
    logic              out_valid_reg;
    pfa_pkg::result_t  out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= 9'(pfa_pkg::MAX_FRAMES);
        end
        else if (frame_count_we)
        begin
            frame_count_reg <= frame_count_wdata;
        end
    end

    // clamp the managed count into 1..MAX_FRAMES
    always_comb
    begin
        priority if (frame_count_reg == 9'd0)
        begin
            n = CW'(1);
        end
        else if (frame_count_reg > 9'(pfa_pkg::MAX_FRAMES))
        begin
            n = CW'(pfa_pkg::MAX_FRAMES);
        end
        else
        begin
            n = CW'(frame_count_reg);
        end
    end

    pfa_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .n             (n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .owner_pid     (owner_pid),
        .virtual_page  (virtual_page),
        .run_length    (run_length),
        .free_frame    (free_frame),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign frame        = out_reg.frame;
    assign evicted      = out_reg.evicted;
    assign evicted_pid  = out_reg.pid;
    assign evicted_page = out_reg.page;
    assign kernel_tag   = out_reg.tag;
    assign last         = out_reg.last;

    // no new transaction is taken while a command still produces results
    a_busy_when_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !in_ready)
        else $error("input taken while results pending");

    // an eviction always reports success
    a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> status == pfa_pkg::ST_OK)
        else $error("eviction with failing status");

    // a failing result ends the command and carries frame zero
    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != pfa_pkg::ST_OK |-> last && frame == 8'd0)
        else $error("failing result not final or frame nonzero");

endmodule
`default_nettype wire

// File: test/page_frame_allocator_tb.sv
// Self-checking testbench for page_frame_allocator: directed table, then random phases.
// Depends on pfa_pkg and the page_frame_allocator RTL; keeps its own frame table model.
`timescale 1ns / 1ps
module page_frame_allocator_tb;

    localparam int CYCLE_LIMIT = 10000000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        frame_count_we;
    logic [8:0]  frame_count_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [15:0] owner_pid;
    logic [19:0] virtual_page;
    logic [5:0]  run_length;
    logic [7:0]  free_frame;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [7:0]  frame;
    logic        evicted;
    logic [15:0] evicted_pid;
    logic [19:0] evicted_page;
    logic [19:0] kernel_tag;
    logic        last;

    page_frame_allocator dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .frame_count_we    (frame_count_we),
        .frame_count_wdata (frame_count_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .owner_pid         (owner_pid),
        .virtual_page      (virtual_page),
        .run_length        (run_length),
        .free_frame        (free_frame),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .frame             (frame),
        .evicted           (evicted),
        .evicted_pid       (evicted_pid),
        .evicted_page      (evicted_page),
        .kernel_tag        (kernel_tag),
        .last              (last)
    );

    // Frame table mirror
    logic [1:0]  kind_mirror [pfa_pkg::MAX_FRAMES];
    logic [15:0] pid_mirror  [pfa_pkg::MAX_FRAMES];
    logic [19:0] tag_mirror  [pfa_pkg::MAX_FRAMES];
    int unsigned victim_ptr;
    logic [19:0] next_tag;
    logic [8:0]  frame_limit;

    pfa_pkg::result_t pending_results[$];
    int          error_count = 0;
    int unsigned cycle_count = 0;
    int          sender_idle_pct;
    int          receiver_stall_pct;

    typedef struct {
        int          fc;
        logic [1:0]  cmd;
        logic [15:0] pid;
        logic [19:0] page;
        logic [5:0]  wanted;
        logic [7:0]  ff;
        bit          typed;
        logic [1:0]  st;
        logic [7:0]  frm;
    } txn_row_t;

    txn_row_t directed_rows[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned managed_frames();
        int unsigned n;
        begin
            n = frame_limit;
            if (n == 0) n = 1;
            if (n > pfa_pkg::MAX_FRAMES) n = pfa_pkg::MAX_FRAMES;
            return n;
        end
    endfunction

    function automatic int unsigned count_free(int unsigned n);
        int unsigned c;
        begin
            c = 0;
            for (int unsigned i = 0; i < n; i++)
                if (kind_mirror[i] == pfa_pkg::KIND_FREE) c++;
            return c;
        end
    endfunction

    function automatic void release_frame(int unsigned f);
        kind_mirror[f] = pfa_pkg::KIND_FREE;
        pid_mirror[f]  = '0;
        tag_mirror[f]  = '0;
    endfunction

    function automatic void push_result(logic [1:0] st, int unsigned frm, logic ev,
                                        logic [15:0] vpid, logic [19:0] vpage,
                                        logic [19:0] tg, logic lst);
        pfa_pkg::result_t r;
        begin
            r.status  = st;
            r.frame   = frm[7:0];
            r.evicted = ev;
            r.pid     = vpid;
            r.page    = vpage;
            r.tag     = tg;
            r.last    = lst;
            pending_results.push_back(r);
        end
    endfunction

    // Round-robin eviction of one user frame; returns 0 when none exists.
    function automatic bit evict_user(int unsigned n, output int unsigned vf,
                                      output logic [15:0] vpid, output logic [19:0] vpage);
        int unsigned p;
        begin
            vf = 0;
            vpid = '0;
            vpage = '0;
            p = (victim_ptr >= n) ? 0 : victim_ptr;
            for (int unsigned i = 0; i < n; i++)
            begin
                if (kind_mirror[p] == pfa_pkg::KIND_USER)
                begin
                    vf = p;
                    vpid = pid_mirror[p];
                    vpage = tag_mirror[p];
                    release_frame(p);
                    victim_ptr = (p + 1 == n) ? 0 : p + 1;
                    return 1'b1;
                end
                p = (p + 1 == n) ? 0 : p + 1;
            end
            return 1'b0;
        end
    endfunction

    function automatic void predict_allocation(logic [1:0] cmd, logic [15:0] pid,
                                               logic [19:0] page, logic [5:0] wanted,
                                               logic [7:0] ff);
        int unsigned n, idx, vf, need, run, start;
        logic [15:0] vpid;
        logic [19:0] vpage, tg;
        begin
            n = managed_frames();
            if (cmd == pfa_pkg::CMD_USER)
            begin
                if (count_free(n) == 0)
                begin
                    if (!evict_user(n, vf, vpid, vpage))
                    begin
                        push_result(pfa_pkg::ST_NO_VICTIM, 0, 1'b0, '0, '0, '0, 1'b1);
                        return;
                    end
                    kind_mirror[vf] = pfa_pkg::KIND_USER;
                    pid_mirror[vf]  = pid;
                    tag_mirror[vf]  = page;
                    push_result(pfa_pkg::ST_OK, vf, 1'b1, vpid, vpage, '0, 1'b1);
                    return;
                end
                idx = n >> 1;
                for (int unsigned i = 0; i < n; i++)
                begin
                    if (kind_mirror[idx] == pfa_pkg::KIND_FREE)
                    begin
                        kind_mirror[idx] = pfa_pkg::KIND_USER;
                        pid_mirror[idx]  = pid;
                        tag_mirror[idx]  = page;
                        push_result(pfa_pkg::ST_OK, idx, 1'b0, '0, '0, '0, 1'b1);
                        return;
                    end
                    idx = (idx + 1 == n) ? 0 : idx + 1;
                end
                push_result(pfa_pkg::ST_NO_VICTIM, 0, 1'b0, '0, '0, '0, 1'b1);
            end
            else if (cmd == pfa_pkg::CMD_KERNEL)
            begin
                if (wanted == 0 || wanted > pfa_pkg::MAX_RUN || wanted > n)
                begin
                    push_result(pfa_pkg::ST_NO_SPACE, 0, 1'b0, '0, '0, '0, 1'b1);
                    return;
                end
                if (wanted > count_free(n))
                begin
                    need = wanted - count_free(n);
                    for (int unsigned i = 0; i < need; i++)
                    begin
                        if (!evict_user(n, vf, vpid, vpage))
                        begin
                            push_result(pfa_pkg::ST_NO_VICTIM, 0, 1'b0, '0, '0, '0, 1'b1);
                            return;
                        end
                        push_result(pfa_pkg::ST_OK, vf, 1'b1, vpid, vpage, '0, 1'b0);
                    end
                end
                run = 0;
                start = 0;
                for (int unsigned i = 0; i < n; i++)
                begin
                    if (kind_mirror[i] == pfa_pkg::KIND_FREE)
                    begin
                        if (run == 0) start = i;
                        run++;
                        if (run == wanted)
                        begin
                            for (int unsigned j = start; j <= i; j++)
                            begin
                                kind_mirror[j] = pfa_pkg::KIND_KERNEL;
                                pid_mirror[j]  = '0;
                                tag_mirror[j]  = next_tag;
                            end
                            push_result(pfa_pkg::ST_OK, start, 1'b0, '0, '0, next_tag, 1'b1);
                            next_tag = next_tag + 20'd1;
                            return;
                        end
                    end
                    else
                        run = 0;
                end
                push_result(pfa_pkg::ST_NO_SPACE, 0, 1'b0, '0, '0, '0, 1'b1);
            end
            else if (cmd == pfa_pkg::CMD_FREE)
            begin
                if (ff >= n || kind_mirror[ff] == pfa_pkg::KIND_FREE)
                begin
                    push_result(pfa_pkg::ST_BAD_FRAME, 0, 1'b0, '0, '0, '0, 1'b1);
                    return;
                end
                if (kind_mirror[ff] == pfa_pkg::KIND_KERNEL)
                begin
                    tg = tag_mirror[ff];
                    for (int unsigned i = 0; i < n; i++)
                        if (kind_mirror[i] == pfa_pkg::KIND_KERNEL && tag_mirror[i] == tg)
                            release_frame(i);
                end
                else
                    release_frame(ff);
                push_result(pfa_pkg::ST_OK, ff, 1'b0, '0, '0, '0, 1'b1);
            end
            else
                push_result(pfa_pkg::ST_BAD_FRAME, 0, 1'b0, '0, '0, '0, 1'b1);
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // Drain and program frame_count while the block sits idle.
    task automatic write_frame_count(input logic [8:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || !in_ready)
            @(posedge clk);
        frame_count_we    <= 1'b1;
        frame_count_wdata <= value;
        frame_limit = value;
        @(posedge clk);
        frame_count_we <= 1'b0;
    endtask

    task automatic send_request(input logic [1:0] cmd, input logic [15:0] pid,
                                input logic [19:0] page, input logic [5:0] wanted,
                                input logic [7:0] ff);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        owner_pid    <= pid;
        virtual_page <= page;
        run_length   <= wanted;
        free_frame   <= ff;
        do
            @(posedge clk);
        while (!in_ready);
        predict_allocation(cmd, pid, page, wanted, ff);
    endtask

    function automatic txn_row_t make_row(int fc, logic [1:0] cmd, logic [15:0] pid,
                                          logic [19:0] page, logic [5:0] wanted,
                                          logic [7:0] ff, bit typed, logic [1:0] st,
                                          logic [7:0] frm);
        txn_row_t r;
        begin
            r.fc = fc; r.cmd = cmd; r.pid = pid; r.page = page; r.wanted = wanted;
            r.ff = ff; r.typed = typed; r.st = st; r.frm = frm;
            return r;
        end
    endfunction

    // Result side: check and randomize backpressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected transaction", 1, 0);
                end
                else
                begin
                    pfa_pkg::result_t e;
                    e = pending_results.pop_front();
                    if (status !== e.status)     report_mismatch("status", status, e.status);
                    if (frame !== e.frame)       report_mismatch("frame", frame, e.frame);
                    if (evicted !== e.evicted)   report_mismatch("evicted", evicted, e.evicted);
                    if (evicted_pid !== e.pid)   report_mismatch("evicted_pid", evicted_pid, e.pid);
                    if (evicted_page !== e.page) report_mismatch("evicted_page", evicted_page,
                                                                 e.page);
                    if (kernel_tag !== e.tag)    report_mismatch("kernel_tag", kernel_tag, e.tag);
                    if (last !== e.last)         report_mismatch("last", last, e.last);
                end
            end
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("page_frame_allocator_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [8:0]  phase_counts [8];
        int unsigned n, pick, sel;
        logic [1:0]  cmd;
        logic [5:0]  wanted;
        logic [7:0]  ff;
        int          last_idx;

        phase_counts = '{9'd4, 9'd16, 9'd256, 9'd300, 9'd1, 9'd37, 9'd511, 9'd8};
        rst_n = 1'b0;
        frame_count_we = 1'b0;
        frame_count_wdata = '0;
        in_valid = 1'b0;
        command = '0;
        owner_pid = '0;
        virtual_page = '0;
        run_length = '0;
        free_frame = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        for (int i = 0; i < pfa_pkg::MAX_FRAMES; i++)
            release_frame(i);
        victim_ptr = 0;
        next_tag = '0;
        frame_limit = 9'd256;

        // fc of -1 keeps the current frame count
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_USER, 16'hFFFF, 20'hFFFFF, 0, 0,
                                         1, pfa_pkg::ST_OK, 128));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_USER, 16'd1, 20'd0, 0, 0,
                                         1, pfa_pkg::ST_OK, 129));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_KERNEL, 0, 0, 6'd0, 0,
                                         1, pfa_pkg::ST_NO_SPACE, 0));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_KERNEL, 0, 0, 6'd33, 0,
                                         1, pfa_pkg::ST_NO_SPACE, 0));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_KERNEL, 0, 0, 6'd63, 0,
                                         1, pfa_pkg::ST_NO_SPACE, 0));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_KERNEL, 0, 0, 6'd32, 0, 0, 0, 0));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_KERNEL, 0, 0, 6'd1, 0, 0, 0, 0));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_FREE, 0, 0, 0, 8'd255,
                                         1, pfa_pkg::ST_BAD_FRAME, 0));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_FREE, 0, 0, 0, 8'd128,
                                         1, pfa_pkg::ST_OK, 128));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_FREE, 0, 0, 0, 8'd0,
                                         1, pfa_pkg::ST_OK, 0));
        directed_rows.push_back(make_row(-1, 2'd3, 16'h5A5A, 20'h12345, 6'd5, 8'd7,
                                         1, pfa_pkg::ST_BAD_FRAME, 0));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_FREE, 0, 0, 0, 8'd128,
                                         1, pfa_pkg::ST_BAD_FRAME, 0));
        // frame count of zero acts as a single frame
        directed_rows.push_back(make_row(0, pfa_pkg::CMD_USER, 16'd7, 20'h00007, 0, 0,
                                         1, pfa_pkg::ST_OK, 0));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_USER, 16'd9, 20'h80000, 0, 0,
                                         0, 0, 0));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_KERNEL, 0, 0, 6'd1, 0, 0, 0, 0));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_USER, 16'd3, 20'd3, 0, 0,
                                         1, pfa_pkg::ST_NO_VICTIM, 0));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_KERNEL, 0, 0, 6'd2, 0,
                                         1, pfa_pkg::ST_NO_SPACE, 0));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_FREE, 0, 0, 0, 8'd1,
                                         1, pfa_pkg::ST_BAD_FRAME, 0));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_FREE, 0, 0, 0, 8'd0,
                                         1, pfa_pkg::ST_OK, 0));
        // three frames: one user frame, then kernel runs that fail to fit and that evict it
        directed_rows.push_back(make_row(3, pfa_pkg::CMD_USER, 16'd4, 20'd44, 0, 0,
                                         1, pfa_pkg::ST_OK, 1));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_KERNEL, 0, 0, 6'd2, 0, 0, 0, 0));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_KERNEL, 0, 0, 6'd3, 0, 0, 0, 0));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_FREE, 0, 0, 0, 8'd1, 0, 0, 0));
        directed_rows.push_back(make_row(-1, pfa_pkg::CMD_KERNEL, 0, 0, 6'd3, 0, 0, 0, 0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].fc >= 0)
                write_frame_count(directed_rows[i].fc[8:0]);
            send_request(directed_rows[i].cmd, directed_rows[i].pid, directed_rows[i].page,
                         directed_rows[i].wanted, directed_rows[i].ff);
            // typed rows give a single result, the newest one in the queue
            if (directed_rows[i].typed)
            begin
                last_idx = pending_results.size() - 1;
                pending_results[last_idx].status = directed_rows[i].st;
                pending_results[last_idx].frame  = directed_rows[i].frm;
            end
        end

        for (int phase = 0; phase < 8; phase++)
        begin
            write_frame_count(phase_counts[phase]);
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
                default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
            endcase
            n = managed_frames();
            for (int k = 0; k < 25; k++)
            begin
                sel = $urandom_range(99);
                wanted = 6'($urandom_range(1, (n < 8) ? n : 8));
                ff = 8'($urandom);
                if (sel < 45)
                    cmd = pfa_pkg::CMD_USER;
                else if (sel < 70)
                begin
                    cmd = pfa_pkg::CMD_KERNEL;
                    if ($urandom_range(9) == 0) wanted = 6'($urandom);
                end
                else if (sel < 95)
                begin
                    cmd = pfa_pkg::CMD_FREE;
                    // aim most frees at a frame in use
                    if ($urandom_range(9) != 0)
                        for (int t = 0; t < 8; t++)
                        begin
                            pick = $urandom_range(n - 1);
                            if (kind_mirror[pick] != pfa_pkg::KIND_FREE)
                            begin
                                ff = 8'(pick);
                                break;
                            end
                        end
                end
                else
                    cmd = 2'd3;
                send_request(cmd, 16'($urandom), 20'($urandom), wanted, ff);
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("page_frame_allocator_tb: done, clean");
        else
            $display("page_frame_allocator_tb: done, errors");
        $finish;
    end

endmodule
